### design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TMK_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error("thin multipole kick assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TMK_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("thin multipole kick assertion failed");

`endif

### design/tmk_pkg.sv
// Types, constants and fixed-point helpers for the thin multipole kick block.
`default_nettype none

package tmk_pkg;

	// Q16.24 word and multiplier slicing.
	localparam int QW     = 40;
	localparam int FRAC_W = 24;
	localparam int HW     = 20;
	localparam int PART_W = QW + HW;
	localparam int PROD_W = 2 * QW;
	localparam int MAG_W  = PROD_W - FRAC_W;
	localparam int ACC_W  = QW + 2;
	localparam int SUM_W  = QW + 3;

	localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (FRAC_W - 1);
	localparam logic [MAG_W-1:0]  MAG_NEG_LIM = MAG_W'(1) << (QW - 1);
	localparam logic [MAG_W-1:0]  MAG_POS_LIM = (MAG_W'(1) << (QW - 1)) - MAG_W'(1);
	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

	// Stream and configuration port widths.
	localparam int S_TDATA_W = 328;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 240;
	localparam int M_TUSER_W = 1;
	localparam int CFG_AW    = 2;
	localparam int ORDER_W   = 4;

	// Configuration register indexes.
	localparam logic [CFG_AW-1:0] CFG_HIGHEST_ORDER = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_BEND_X        = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_BEND_Y        = 2'd2;

	// Item kinds.
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_KICK = 1'b1;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_INIT = 11'b000_0000_0010,
		ST_LOAD = 11'b000_0000_0100,
		ST_MLO  = 11'b000_0000_1000,
		ST_MHI  = 11'b000_0001_0000,
		ST_SUM  = 11'b000_0010_0000,
		ST_ACC  = 11'b000_0100_0000,
		ST_FIN  = 11'b000_1000_0000,
		ST_PRE  = 11'b001_0000_0000,
		ST_PATH = 11'b010_0000_0000,
		ST_OUT  = 11'b100_0000_0000
	} state_t;

	// Products issued to the shared multiplier, in program order.
	typedef enum logic [2:0] {
		OP_RE_X = 3'd0,
		OP_IM_Y = 3'd1,
		OP_IM_X = 3'd2,
		OP_RE_Y = 3'd3,
		OP_BX_D = 3'd4,
		OP_BY_D = 3'd5,
		OP_BX_X = 3'd6,
		OP_BY_Y = 3'd7
	} op_t;

	function automatic logic [QW-1:0] mag(input logic signed [QW-1:0] a);
		return a[QW-1] ? (~a + QW'(1)) : a;
	endfunction

	function automatic logic signed [SUM_W-1:0] sx(input logic signed [QW-1:0] a);
		return {{(SUM_W-QW){a[QW-1]}}, a};
	endfunction

	// Clamp a sum to the Q16.24 range.
	function automatic logic signed [QW-1:0] sat(input logic signed [SUM_W-1:0] v);
		logic [SUM_W-QW:0] top;
		top = v[SUM_W-1:QW-1];
		if (!v[SUM_W-1] && (|top)) return Q_MAX;
		if (v[SUM_W-1] && !(&top)) return Q_MIN;
		return v[QW-1:0];
	endfunction

endpackage

`default_nettype wire

### design/tmk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tmk_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  wire logic                                          clk,
	input  wire logic                                          we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                              wdata,
	input  wire logic                                          re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic      [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

### design/thin_multipole_kick.sv
// Top level of the thin multipole kick: coefficient table, sequencer and shared multiplier.
`default_nettype none

// The block applies a thin-lens multipole kick to one particle at a time. A load item
// (tuser bit 0 low) writes one skew/normal coefficient pair into the table at coef_index
// and leaves the input side ready for the next item; it gives no result, and an index
// at or beyond NUM_COEFFS is dropped. A kick item (tuser bit 0 high) evaluates sum of
// (B[n] + iA[n])(x + iy)^n by Horner's rule up to highest_order (clamped to
// NUM_COEFFS-1), subtracts the real part from px, adds the imaginary part to py, then
// applies the bending terms from bend_x and bend_y with the particle's own delta, x and
// y. All arithmetic is signed Q16.24 in 40 bits: every product is rounded to nearest
// with ties away from zero and saturated, and every sum is saturated. A single 40 by 20
// bit multiplier does all the work; each product goes through operand magnitude, low
// half, high half, round and accumulate, in that order. A kick item keeps the input side
// busy until its result is in the output register; a lost particle (tuser bit 1 high)
// passes through unchanged. The result sits in an output register, so a
// new item is taken while the previous result still waits for the downstream side; a
// finished result waits only if the one before it has not been taken. The coefficient
// table resets to zeros through one valid flag per entry, so there is no clearing pass.
// Configuration registers should be written only while no kick item is in flight.
module thin_multipole_kick #(
	parameter int NUM_COEFFS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Input stream.
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// coef_index[3:0], coef_skew[43:4], coef_normal[83:44], in_x[123:84], in_px[163:124],
	// in_y[203:164], in_py[243:204], in_delta[283:244], in_path[323:284], zeros[327:324]
	input  wire logic [tmk_pkg::S_TDATA_W-1:0]        s_axis_tdata,
	// mode[0], in_lost[1]
	input  wire logic [tmk_pkg::S_TUSER_W-1:0]        s_axis_tuser,
	input  wire logic                                 s_axis_tlast,
	// Result stream.
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// out_x[39:0], out_px[79:40], out_y[119:80], out_py[159:120], out_delta[199:160],
	// out_path[239:200]
	output logic      [tmk_pkg::M_TDATA_W-1:0]        m_axis_tdata,
	// out_lost[0]
	output logic      [tmk_pkg::M_TUSER_W-1:0]        m_axis_tuser,
	output logic                                      m_axis_tlast,
	// Configuration write port.
	input  wire logic                                 cfg_we,
	input  wire logic [tmk_pkg::CFG_AW-1:0]           cfg_addr,
	input  wire logic [tmk_pkg::QW-1:0]               cfg_wdata
);

	localparam int AW = (NUM_COEFFS > 1) ? $clog2(NUM_COEFFS) : 1;
	localparam int CW = (AW > tmk_pkg::ORDER_W) ? AW : tmk_pkg::ORDER_W;
	localparam int QW = tmk_pkg::QW;

	// Input fields.
	logic                   mode;
	logic                   in_lost;
	logic                   in_last;
	logic [3:0]             coef_index;
	logic signed [QW-1:0]   coef_skew;
	logic signed [QW-1:0]   coef_normal;
	logic signed [QW-1:0]   in_x;
	logic signed [QW-1:0]   in_px;
	logic signed [QW-1:0]   in_y;
	logic signed [QW-1:0]   in_py;
	logic signed [QW-1:0]   in_delta;
	logic signed [QW-1:0]   in_path;

	assign mode        = s_axis_tuser[0];
	assign in_lost     = s_axis_tuser[1];
	assign in_last     = s_axis_tlast;
	assign coef_index  = s_axis_tdata[3:0];
	assign coef_skew   = s_axis_tdata[43:4];
	assign coef_normal = s_axis_tdata[83:44];
	assign in_x        = s_axis_tdata[123:84];
	assign in_px       = s_axis_tdata[163:124];
	assign in_y        = s_axis_tdata[203:164];
	assign in_py       = s_axis_tdata[243:204];
	assign in_delta    = s_axis_tdata[283:244];
	assign in_path     = s_axis_tdata[323:284];

	// Control state.
	tmk_pkg::state_t              state_q;
	tmk_pkg::op_t                 op_q;
	logic                         m_valid_q;
	logic [NUM_COEFFS-1:0]        vld_q;
	logic [tmk_pkg::ORDER_W-1:0]  order_q;
	logic signed [QW-1:0]         bend_x_q;
	logic signed [QW-1:0]         bend_y_q;

	// Particle and working registers.
	logic signed [QW-1:0]              x_q, px_q, y_q, py_q, dl_q, path_q;
	logic                              lost_q, last_q;
	logic signed [QW-1:0]              re_q, im_q, t_q;
	logic signed [tmk_pkg::ACC_W-1:0]  acc_q;
	logic [AW-1:0]                     i_q;
	logic                              rd_vld_q;

	// Shared multiplier registers.
	logic [QW-1:0]                  ua_q, ub_q;
	logic                           neg_q;
	logic [tmk_pkg::PART_W-1:0]     plo_q, phi_q;
	logic [tmk_pkg::MAG_W-1:0]      m_q;

	// Result registers.
	logic [tmk_pkg::M_TDATA_W-1:0]  m_tdata_q;
	logic                           m_tuser_q;
	logic                           m_tlast_q;

	logic s_accept;
	logic out_free;
	assign s_axis_tready = (state_q == tmk_pkg::ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	// Coefficient table: skew in the low half, normal in the high half.
	logic                load_ok;
	logic [CW-1:0]       idx_ext;
	logic [CW-1:0]       ord_ext;
	logic [AW-1:0]       ord_clamp;
	logic                tbl_we;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [2*QW-1:0]     rd_data;
	logic signed [QW-1:0] tbl_skew, tbl_normal;

	assign load_ok   = int'(coef_index) < NUM_COEFFS;
	assign idx_ext   = CW'(coef_index);
	assign ord_ext   = CW'(order_q);
	assign ord_clamp = (int'(order_q) > NUM_COEFFS - 1) ? AW'(NUM_COEFFS - 1) : ord_ext[AW-1:0];
	assign tbl_we    = s_accept && (mode == tmk_pkg::MODE_LOAD) && load_ok;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q - AW'(1);
		case (state_q)
			tmk_pkg::ST_IDLE: begin
				rd_en   = s_accept && (mode == tmk_pkg::MODE_KICK);
				rd_addr = ord_clamp;
			end
			tmk_pkg::ST_INIT: begin
				rd_en = (i_q != '0);
			end
			tmk_pkg::ST_FIN: begin
				rd_en = (op_q == tmk_pkg::OP_RE_Y) && (i_q != '0);
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	tmk_ram #(
		.WIDTH(2 * QW),
		.DEPTH(NUM_COEFFS)
	) u_tmk_ram (
		.clk  (clk),
		.we   (tbl_we),
		.waddr(idx_ext[AW-1:0]),
		.wdata({coef_normal, coef_skew}),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	// Entries never written read as zero.
	assign tbl_skew   = rd_vld_q ? rd_data[QW-1:0] : '0;
	assign tbl_normal = rd_vld_q ? rd_data[2*QW-1:QW] : '0;

	// Operand selection and program order of the multiplier.
	logic signed [QW-1:0] opa, opb;
	logic                 op_first, op_sub, op_last;
	tmk_pkg::op_t         op_next;

	always_comb begin
		case (op_q)
			tmk_pkg::OP_RE_X: begin opa = re_q;     opb = x_q;  op_next = tmk_pkg::OP_IM_Y; end
			tmk_pkg::OP_IM_Y: begin opa = im_q;     opb = y_q;  op_next = tmk_pkg::OP_IM_X; end
			tmk_pkg::OP_IM_X: begin opa = im_q;     opb = x_q;  op_next = tmk_pkg::OP_RE_Y; end
			tmk_pkg::OP_RE_Y: begin opa = re_q;     opb = y_q;  op_next = tmk_pkg::OP_BX_D; end
			tmk_pkg::OP_BX_D: begin opa = bend_x_q; opb = dl_q; op_next = tmk_pkg::OP_BY_D; end
			tmk_pkg::OP_BY_D: begin opa = bend_y_q; opb = dl_q; op_next = tmk_pkg::OP_BX_X; end
			tmk_pkg::OP_BX_X: begin opa = bend_x_q; opb = x_q;  op_next = tmk_pkg::OP_BY_Y; end
			tmk_pkg::OP_BY_Y: begin opa = bend_y_q; opb = y_q;  op_next = tmk_pkg::OP_RE_X; end
			default: begin opa = re_q; opb = x_q; op_next = tmk_pkg::OP_RE_X; end
		endcase
	end

	assign op_first = op_q inside {tmk_pkg::OP_RE_X, tmk_pkg::OP_IM_X, tmk_pkg::OP_BX_D,
		tmk_pkg::OP_BY_D, tmk_pkg::OP_BX_X};
	assign op_sub   = op_q inside {tmk_pkg::OP_IM_Y, tmk_pkg::OP_BY_Y};
	assign op_last  = op_q inside {tmk_pkg::OP_IM_Y, tmk_pkg::OP_RE_Y, tmk_pkg::OP_BX_D,
		tmk_pkg::OP_BY_D, tmk_pkg::OP_BY_Y};

	// The one 40 by 20 bit multiplier takes the low half of the second operand first and
	// the high half on the next cycle.
	logic [tmk_pkg::HW-1:0]      ub_part;
	logic [tmk_pkg::PART_W-1:0]  part_prod;

	assign ub_part   = (state_q == tmk_pkg::ST_MHI) ? ub_q[QW-1:tmk_pkg::HW]
		: ub_q[tmk_pkg::HW-1:0];
	assign part_prod = tmk_pkg::PART_W'(ua_q) * tmk_pkg::PART_W'(ub_part);

	// Rounding and saturation of the finished product, then accumulation.
	logic [tmk_pkg::PROD_W-1:0]        psum;
	logic signed [QW-1:0]              prod_r;
	logic signed [tmk_pkg::ACC_W-1:0]  prod_ext, acc_base, acc_next;

	assign psum = {{tmk_pkg::HW{1'b0}}, plo_q} + {phi_q, {tmk_pkg::HW{1'b0}}}
		+ tmk_pkg::ROUND_BIAS;

	always_comb begin
		if (neg_q) begin
			prod_r = (m_q > tmk_pkg::MAG_NEG_LIM) ? tmk_pkg::Q_MIN : -m_q[QW-1:0];
		end else begin
			prod_r = (m_q > tmk_pkg::MAG_POS_LIM) ? tmk_pkg::Q_MAX : m_q[QW-1:0];
		end
	end

	assign prod_ext = {{(tmk_pkg::ACC_W-QW){prod_r[QW-1]}}, prod_r};
	assign acc_base = op_first ? '0 : acc_q;
	assign acc_next = op_sub ? (acc_base - prod_ext) : (acc_base + prod_ext);

	// Closing sums, each saturated once.
	logic signed [tmk_pkg::SUM_W-1:0] acc_sx, fin_sum;
	logic signed [QW-1:0]             fin_sat;

	assign acc_sx = {acc_q[tmk_pkg::ACC_W-1], acc_q};

	always_comb begin
		case (op_q)
			tmk_pkg::OP_IM_Y: fin_sum = acc_sx + tmk_pkg::sx(tbl_normal);
			tmk_pkg::OP_RE_Y: fin_sum = acc_sx + tmk_pkg::sx(tbl_skew);
			tmk_pkg::OP_BX_D: fin_sum = tmk_pkg::sx(px_q) + acc_sx;
			tmk_pkg::OP_BY_D: fin_sum = tmk_pkg::sx(py_q) - acc_sx;
			default:          fin_sum = acc_sx;
		endcase
	end

	assign fin_sat = tmk_pkg::sat(fin_sum);

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tmk_pkg::ST_IDLE;
			op_q      <= tmk_pkg::OP_RE_X;
			m_valid_q <= 1'b0;
			vld_q     <= '0;
			order_q   <= '0;
			bend_x_q  <= '0;
			bend_y_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					tmk_pkg::CFG_HIGHEST_ORDER: order_q  <= cfg_wdata[tmk_pkg::ORDER_W-1:0];
					tmk_pkg::CFG_BEND_X:        bend_x_q <= cfg_wdata;
					tmk_pkg::CFG_BEND_Y:        bend_y_q <= cfg_wdata;
					default: ;
				endcase
			end

			if (tbl_we) begin
				vld_q[idx_ext[AW-1:0]] <= 1'b1;
			end

			if ((state_q == tmk_pkg::ST_OUT) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				tmk_pkg::ST_IDLE: begin
					if (s_accept && (mode == tmk_pkg::MODE_KICK)) begin
						state_q <= in_lost ? tmk_pkg::ST_OUT : tmk_pkg::ST_INIT;
					end
				end
				tmk_pkg::ST_INIT: begin
					if (i_q == '0) begin
						state_q <= tmk_pkg::ST_PRE;
					end else begin
						op_q    <= tmk_pkg::OP_RE_X;
						state_q <= tmk_pkg::ST_LOAD;
					end
				end
				tmk_pkg::ST_LOAD: state_q <= tmk_pkg::ST_MLO;
				tmk_pkg::ST_MLO:  state_q <= tmk_pkg::ST_MHI;
				tmk_pkg::ST_MHI:  state_q <= tmk_pkg::ST_SUM;
				tmk_pkg::ST_SUM:  state_q <= tmk_pkg::ST_ACC;
				tmk_pkg::ST_ACC: begin
					if (op_last) begin
						state_q <= tmk_pkg::ST_FIN;
					end else begin
						op_q    <= op_next;
						state_q <= tmk_pkg::ST_LOAD;
					end
				end
				tmk_pkg::ST_FIN: begin
					case (op_q)
						tmk_pkg::OP_RE_Y: begin
							if (i_q == '0) begin
								state_q <= tmk_pkg::ST_PRE;
							end else begin
								op_q    <= tmk_pkg::OP_RE_X;
								state_q <= tmk_pkg::ST_LOAD;
							end
						end
						tmk_pkg::OP_BY_Y: begin
							state_q <= tmk_pkg::ST_PATH;
						end
						default: begin
							op_q    <= op_next;
							state_q <= tmk_pkg::ST_LOAD;
						end
					endcase
				end
				tmk_pkg::ST_PRE: begin
					op_q    <= tmk_pkg::OP_BX_D;
					state_q <= tmk_pkg::ST_LOAD;
				end
				tmk_pkg::ST_PATH: state_q <= tmk_pkg::ST_OUT;
				tmk_pkg::ST_OUT: begin
					if (out_free) begin
						state_q <= tmk_pkg::ST_IDLE;
					end
				end
				default: state_q <= tmk_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_vld_q <= vld_q[rd_addr];
		end

		case (state_q)
			tmk_pkg::ST_IDLE: begin
				if (s_accept && (mode == tmk_pkg::MODE_KICK)) begin
					x_q    <= in_x;
					px_q   <= in_px;
					y_q    <= in_y;
					py_q   <= in_py;
					dl_q   <= in_delta;
					path_q <= in_path;
					lost_q <= in_lost;
					last_q <= in_last;
					i_q    <= ord_clamp;
				end
			end
			tmk_pkg::ST_INIT: begin
				re_q <= tbl_normal;
				im_q <= tbl_skew;
				if (i_q != '0) begin
					i_q <= i_q - AW'(1);
				end
			end
			tmk_pkg::ST_LOAD: begin
				ua_q  <= tmk_pkg::mag(opa);
				ub_q  <= tmk_pkg::mag(opb);
				neg_q <= opa[QW-1] ^ opb[QW-1];
			end
			tmk_pkg::ST_MLO: begin
				plo_q <= part_prod;
			end
			tmk_pkg::ST_MHI: begin
				phi_q <= part_prod;
			end
			tmk_pkg::ST_SUM: begin
				m_q <= psum[tmk_pkg::PROD_W-1:tmk_pkg::FRAC_W];
			end
			tmk_pkg::ST_ACC: begin
				acc_q <= acc_next;
			end
			tmk_pkg::ST_FIN: begin
				case (op_q)
					tmk_pkg::OP_IM_Y: t_q <= fin_sat;
					tmk_pkg::OP_RE_Y: begin
						im_q <= fin_sat;
						re_q <= t_q;
						if (i_q != '0) begin
							i_q <= i_q - AW'(1);
						end
					end
					tmk_pkg::OP_BX_D: px_q <= fin_sat;
					tmk_pkg::OP_BY_D: py_q <= fin_sat;
					tmk_pkg::OP_BY_Y: t_q  <= fin_sat;
					default: ;
				endcase
			end
			tmk_pkg::ST_PRE: begin
				px_q <= tmk_pkg::sat(tmk_pkg::sx(px_q) - tmk_pkg::sx(re_q));
				py_q <= tmk_pkg::sat(tmk_pkg::sx(py_q) + tmk_pkg::sx(im_q));
			end
			tmk_pkg::ST_PATH: begin
				path_q <= tmk_pkg::sat(tmk_pkg::sx(path_q) - tmk_pkg::sx(t_q));
			end
			tmk_pkg::ST_OUT: begin
				if (out_free) begin
					m_tdata_q <= {path_q, dl_q, py_q, y_q, px_q, x_q};
					m_tuser_q <= lost_q;
					m_tlast_q <= last_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_tdata_q;
	assign m_axis_tuser[0] = m_tuser_q;
	assign m_axis_tlast    = m_tlast_q;

endmodule

`default_nettype wire

### design/tmk_checker.sv
// Port-level checker for the thin multipole kick, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tmk_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_axis_tvalid,
	input wire logic                              s_axis_tready,
	input wire logic [tmk_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	input wire logic [tmk_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [tmk_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input wire logic [tmk_pkg::M_TUSER_W-1:0]     m_axis_tuser
);

	logic s_acc;
	logic load_acc;
	logic kick_acc;
	logic lost_acc;
	logic out_wait;
	logic lost_match;
	logic [tmk_pkg::QW-1:0] lost_px_q;
	logic [tmk_pkg::QW-1:0] lost_path_q;

	assign s_acc    = s_axis_tvalid && s_axis_tready;
	assign load_acc = s_acc && (s_axis_tuser[0] == tmk_pkg::MODE_LOAD);
	assign kick_acc = s_acc && (s_axis_tuser[0] == tmk_pkg::MODE_KICK);
	assign lost_acc = kick_acc && s_axis_tuser[1];
	assign out_wait = m_axis_tvalid && !m_axis_tready;

	// Coordinates of the most recent lost particle taken in.
	always_ff @(posedge clk) begin
		if (lost_acc) begin
			lost_px_q   <= s_axis_tdata[163:124];
			lost_path_q <= s_axis_tdata[323:284];
		end
	end

	assign lost_match = m_axis_tuser[0] && (m_axis_tdata[79:40] == lost_px_q)
		&& (m_axis_tdata[239:200] == lost_path_q);

	// A result that is not taken stays put.
	`TMK_ASSERT_NXT(a_out_hold, out_wait, m_axis_tvalid && $stable(m_axis_tdata))

	// A load item never makes a result appear.
	`TMK_ASSERT_NXT(a_load_silent, load_acc && !m_axis_tvalid, !m_axis_tvalid)

	// A kick item keeps the input side busy for at least the next cycle.
	`TMK_ASSERT_NXT(a_kick_busy, kick_acc, !s_axis_tready)

	// A lost particle leaves via the output register with px and path untouched.
	`TMK_ASSERT_IMP(a_lost_pass, lost_acc && !m_axis_tvalid, ##2 (m_axis_tvalid && lost_match))

endmodule

bind thin_multipole_kick tmk_checker u_tmk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.s_axis_tdata (s_axis_tdata),
	.s_axis_tuser (s_axis_tuser),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);

`default_nettype wire

### tb/sv/thin_multipole_kick_tb.sv
// Self-checking testbench for the thin multipole kick with a predicting scoreboard.
`timescale 1ns / 1ps

module thin_multipole_kick_tb;

	localparam int N_COEFF = 16;
	// Cycles without any handshake or register write before the run is declared hung.
	// The slowest item is a kick at order fifteen plus both stall limits.
	localparam int WATCHDOG_LIMIT = 3000;
	// Cycles of quiet after the last result before registers are touched or the run ends.
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 156;

	typedef logic signed [tmk_pkg::QW-1:0] q_t;

	// One input item: either a coefficient load or a particle to kick.
	typedef struct {
		logic       mode;
		logic [3:0] coef_index;
		q_t         coef_skew;
		q_t         coef_normal;
		q_t         x;
		q_t         px;
		q_t         y;
		q_t         py;
		q_t         delta;
		q_t         path;
		logic       lost;
		logic       last;
	} particle_item_t;

	// One result item: the six coordinates after the kick plus the two flags.
	typedef struct {
		q_t   x;
		q_t   px;
		q_t   y;
		q_t   py;
		q_t   delta;
		q_t   path;
		logic lost;
		logic last;
	} particle_result_t;

	// The scoreboard keeps its own copy of the coefficient table and the registers, works
	// out the kicked coordinates of every accepted particle and checks results in order.
	class kick_scoreboard;
		longint skew_tab[N_COEFF];
		longint normal_tab[N_COEFF];
		int     order;
		longint bend_x;
		longint bend_y;
		particle_result_t kicked_particles[$];
		int errors;
		int kicks_checked;
		int lost_checked;
		int loads_seen;

		function new();
			for (int i = 0; i < N_COEFF; i++) begin
				skew_tab[i] = 0;
				normal_tab[i] = 0;
			end
			order = 0;
			bend_x = 0;
			bend_y = 0;
			errors = 0;
			kicks_checked = 0;
			lost_checked = 0;
			loads_seen = 0;
		endfunction

		function longint clamp_q(longint v);
			if (v > longint'(tmk_pkg::Q_MAX)) return longint'(tmk_pkg::Q_MAX);
			if (v < longint'(tmk_pkg::Q_MIN)) return longint'(tmk_pkg::Q_MIN);
			return v;
		endfunction

		// Q16.24 product: exact magnitude, rounded half away from zero, then saturated.
		function longint mul_q(longint a, longint b);
			bit neg;
			logic [79:0] ua;
			logic [79:0] ub;
			logic [79:0] m;
			neg = (a < 0) != (b < 0);
			ua = (a < 0) ? 80'(-a) : 80'(a);
			ub = (b < 0) ? 80'(-b) : 80'(b);
			m = (ua * ub + 80'h80_0000) >> tmk_pkg::FRAC_W;
			if (neg) begin
				if (m > 80'd549755813888) return longint'(tmk_pkg::Q_MIN);
				return -longint'(m[63:0]);
			end
			if (m > 80'd549755813887) return longint'(tmk_pkg::Q_MAX);
			return longint'(m[63:0]);
		endfunction

		function void set_reg(logic [tmk_pkg::CFG_AW-1:0] addr, logic [tmk_pkg::QW-1:0] data);
			case (addr)
				tmk_pkg::CFG_HIGHEST_ORDER: order = int'(data[tmk_pkg::ORDER_W-1:0]);
				tmk_pkg::CFG_BEND_X: bend_x = longint'(q_t'(data));
				tmk_pkg::CFG_BEND_Y: bend_y = longint'(q_t'(data));
				default: ;
			endcase
		endfunction

		function void note_input(particle_item_t it);
			particle_result_t r;
			longint x;
			longint px;
			longint y;
			longint py;
			longint dl;
			longint path;
			longint re;
			longint im;
			longint t;
			int ord;
			if (it.mode == tmk_pkg::MODE_LOAD) begin
				// An index past the table is dropped without a result.
				if (int'(it.coef_index) < N_COEFF) begin
					skew_tab[it.coef_index] = longint'(it.coef_skew);
					normal_tab[it.coef_index] = longint'(it.coef_normal);
				end
				loads_seen++;
				return;
			end
			x = longint'(it.x);
			px = longint'(it.px);
			y = longint'(it.y);
			py = longint'(it.py);
			dl = longint'(it.delta);
			path = longint'(it.path);
			if (!it.lost) begin
				ord = (order > N_COEFF - 1) ? N_COEFF - 1 : order;
				re = normal_tab[ord];
				im = skew_tab[ord];
				// Horner step: (re + i*im) * (x + i*y) + (B[n] + i*A[n]).
				for (int n = ord - 1; n >= 0; n--) begin
					t = clamp_q(mul_q(re, x) - mul_q(im, y) + normal_tab[n]);
					im = clamp_q(mul_q(im, x) + mul_q(re, y) + skew_tab[n]);
					re = t;
				end
				px = clamp_q(px - re);
				py = clamp_q(py + im);
				px = clamp_q(px + mul_q(bend_x, dl));
				py = clamp_q(py - mul_q(bend_y, dl));
				t = clamp_q(mul_q(bend_x, x) - mul_q(bend_y, y));
				path = clamp_q(path - t);
			end
			r.x = q_t'(x);
			r.px = q_t'(px);
			r.y = q_t'(y);
			r.py = q_t'(py);
			r.delta = q_t'(dl);
			r.path = q_t'(path);
			r.lost = it.lost;
			r.last = it.last;
			kicked_particles.push_back(r);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$error("%s mismatch: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(particle_result_t got);
			particle_result_t want;
			if (kicked_particles.size() == 0) begin
				$error("result item arrived with no particle waiting for it");
				errors++;
				return;
			end
			want = kicked_particles.pop_front();
			compare_field("out_x", want.x, got.x);
			compare_field("out_px", want.px, got.px);
			compare_field("out_y", want.y, got.y);
			compare_field("out_py", want.py, got.py);
			compare_field("out_delta", want.delta, got.delta);
			compare_field("out_path", want.path, got.path);
			compare_field("out_lost", want.lost, got.lost);
			compare_field("out_last", want.last, got.last);
			kicks_checked++;
			if (want.lost) lost_checked++;
		endfunction

		function int pending();
			return kicked_particles.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [tmk_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
	logic [tmk_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [tmk_pkg::M_TDATA_W-1:0] m_axis_tdata;
	logic [tmk_pkg::M_TUSER_W-1:0] m_axis_tuser;
	logic m_axis_tlast;
	logic cfg_we = 1'b0;
	logic [tmk_pkg::CFG_AW-1:0] cfg_addr = '0;
	logic [tmk_pkg::QW-1:0] cfg_wdata = '0;

	kick_scoreboard sb = new();
	int idle_cycles = 0;
	int settings_used = 0;
	// Burst flags switch idling off for a while on either side.
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	always #5 clk = ~clk;

	thin_multipole_kick #(
		.NUM_COEFFS(N_COEFF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	// Random Q16.24 value. Most values lie within two of zero, some tiny fractions, so that
	// the polynomial does not simply saturate; the rest cover the full range and extremes.
	function automatic q_t rand_q();
		logic [63:0] r64;
		int pick;
		r64 = {$urandom, $urandom};
		pick = $urandom_range(0, 99);
		if (pick < 25) return q_t'(r64[tmk_pkg::QW-1:0]);
		if (pick < 65) return q_t'({{14{r64[25]}}, r64[25:0]});
		if (pick < 85) return q_t'({{27{r64[12]}}, r64[12:0]});
		case (r64[2:0])
			3'd0: return tmk_pkg::Q_MAX;
			3'd1: return tmk_pkg::Q_MIN;
			3'd2: return q_t'(0);
			3'd3: return q_t'(1);
			3'd4: return q_t'(-1);
			3'd5: return q_t'(40'sd16777216);
			3'd6: return q_t'(-40'sd16777216);
			default: return q_t'(40'sd8388608);
		endcase
	endfunction

	// A random item fills every field, so the fields that the mode ignores toggle too.
	function automatic particle_item_t rand_item();
		particle_item_t it;
		it.mode = ($urandom_range(0, 3) == 0) ? tmk_pkg::MODE_LOAD : tmk_pkg::MODE_KICK;
		it.coef_index = 4'($urandom_range(0, 15));
		it.coef_skew = rand_q();
		it.coef_normal = rand_q();
		it.x = rand_q();
		it.px = rand_q();
		it.y = rand_q();
		it.py = rand_q();
		it.delta = rand_q();
		it.path = rand_q();
		it.lost = ($urandom_range(0, 9) == 0);
		it.last = ($urandom_range(0, 7) == 0);
		return it;
	endfunction

	function automatic particle_item_t make_load(int idx, q_t skew, q_t normal);
		particle_item_t it;
		it = rand_item();
		it.mode = tmk_pkg::MODE_LOAD;
		it.coef_index = 4'(idx);
		it.coef_skew = skew;
		it.coef_normal = normal;
		return it;
	endfunction

	function automatic particle_item_t make_kick(q_t x, q_t px, q_t y, q_t py, q_t dl, q_t path,
			logic lost, logic last);
		particle_item_t it;
		it = rand_item();
		it.mode = tmk_pkg::MODE_KICK;
		it.x = x;
		it.px = px;
		it.y = y;
		it.py = py;
		it.delta = dl;
		it.path = path;
		it.lost = lost;
		it.last = last;
		return it;
	endfunction

	// Offers one item after a random gap and holds it until the block takes it.
	// Called at a falling edge and returns at the falling edge after the handshake.
	task automatic send_item(input particle_item_t it);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 17);
		if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0, it.path, it.delta, it.py, it.y, it.px, it.x,
			it.coef_normal, it.coef_skew, it.coef_index};
		s_axis_tuser <= {it.lost, it.mode};
		s_axis_tlast <= it.last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(it);
		@(negedge clk);
	endtask

	// Drains the block before the registers change. A load gives no result, so a short
	// quiet stretch follows the last result.
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes all three registers back to back; returns at a falling edge.
	task automatic apply_settings(input int ord, input q_t bx, input q_t by);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= tmk_pkg::CFG_HIGHEST_ORDER;
		cfg_wdata <= q_t'(ord);
		sb.set_reg(tmk_pkg::CFG_HIGHEST_ORDER, q_t'(ord));
		@(negedge clk);
		cfg_addr <= tmk_pkg::CFG_BEND_X;
		cfg_wdata <= bx;
		sb.set_reg(tmk_pkg::CFG_BEND_X, bx);
		@(negedge clk);
		cfg_addr <= tmk_pkg::CFG_BEND_Y;
		cfg_wdata <= by;
		sb.set_reg(tmk_pkg::CFG_BEND_Y, by);
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// The downstream side stalls a random number of cycles before each result and checks
	// every result it takes against the oldest prediction.
	initial begin
		int stall;
		particle_result_t got;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 17);
			if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got.x = m_axis_tdata[39:0];
			got.px = m_axis_tdata[79:40];
			got.y = m_axis_tdata[119:80];
			got.py = m_axis_tdata[159:120];
			got.delta = m_axis_tdata[199:160];
			got.path = m_axis_tdata[239:200];
			got.lost = m_axis_tuser[0];
			got.last = m_axis_tlast;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	// Any handshake or register write counts as progress; a long silence is a hang.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int ord;
		q_t bx;
		q_t by;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, low order with unit-scale bends. The first kick sees the table
		// as reset, then the outermost entries get the extreme coefficients.
		apply_settings(2, q_t'(40'sd16777216), q_t'(-40'sd8388608));
		send_item(make_kick(q_t'(40'sd16777216), q_t'(0), q_t'(40'sd8388608), q_t'(0),
			q_t'(40'sd4194304), q_t'(0), 1'b0, 1'b0));
		send_item(make_load(0, tmk_pkg::Q_MAX, tmk_pkg::Q_MIN));
		send_item(make_load(15, tmk_pkg::Q_MIN, tmk_pkg::Q_MAX));
		send_item(make_load(1, q_t'(40'sd8388608), q_t'(-40'sd16777216)));
		send_item(make_load(2, q_t'(-3), q_t'(40'sd8388608)));
		// Coordinates at the range limits drive every sum into saturation.
		send_item(make_kick(tmk_pkg::Q_MAX, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MAX,
			tmk_pkg::Q_MAX, tmk_pkg::Q_MIN, 1'b0, 1'b0));
		send_item(make_kick(tmk_pkg::Q_MIN, tmk_pkg::Q_MAX, tmk_pkg::Q_MAX, tmk_pkg::Q_MIN,
			tmk_pkg::Q_MIN, tmk_pkg::Q_MAX, 1'b0, 1'b1));
		// A lost particle must come back untouched, even with extreme coordinates.
		send_item(make_kick(tmk_pkg::Q_MAX, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MAX,
			tmk_pkg::Q_MAX, tmk_pkg::Q_MIN, 1'b1, 1'b1));
		// One-LSB positions against half-unit coefficients hit the rounding ties.
		send_item(make_kick(q_t'(1), q_t'(-5), q_t'(-1), q_t'(7), q_t'(1), q_t'(-1),
			1'b0, 1'b0));
		send_item(make_kick(q_t'(0), q_t'(0), q_t'(0), q_t'(0), q_t'(0), q_t'(0), 1'b0, 1'b0));
		send_item(make_load(0, q_t'(0), q_t'(0)));
		send_item(make_kick(q_t'(40'sd16777216), q_t'(40'sd1000), q_t'(40'sd16777216),
			q_t'(-40'sd1000), q_t'(-40'sd16777216), q_t'(40'sd33554432), 1'b0, 1'b1));
		drain_block();

		// Directed part at the highest order with the bends at opposite extremes.
		apply_settings(15, tmk_pkg::Q_MAX, tmk_pkg::Q_MIN);
		send_item(make_load(15, q_t'(40'sd1048576), q_t'(-40'sd1048576)));
		send_item(make_load(7, q_t'(-40'sd4194304), q_t'(40'sd2097152)));
		send_item(make_kick(q_t'(40'sd8388608), q_t'(0), q_t'(-40'sd8388608), q_t'(0),
			q_t'(-1), q_t'(0), 1'b0, 1'b0));
		send_item(make_kick(tmk_pkg::Q_MAX, tmk_pkg::Q_MAX, tmk_pkg::Q_MAX, tmk_pkg::Q_MAX,
			tmk_pkg::Q_MAX, tmk_pkg::Q_MAX, 1'b0, 1'b0));
		send_item(make_kick(tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN,
			tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, 1'b0, 1'b1));
		send_item(make_kick(tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, tmk_pkg::Q_MIN,
			tmk_pkg::Q_MIN, tmk_pkg::Q_MIN, 1'b1, 1'b0));
		send_item(make_kick(q_t'(-40'sd16777216), q_t'(40'sd12345), q_t'(40'sd3),
			q_t'(-40'sd777), q_t'(40'sd16777216), q_t'(-40'sd99), 1'b0, 1'b0));
		drain_block();

		// Random phases. Each phase loads coefficients and kicks particles under one
		// setting; the orders include both ends, and one phase swaps the bend extremes.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: ord = 1;
				1: ord = 0;
				2: ord = 4;
				3: ord = 15;
				4: ord = 7;
				6: ord = 3;
				default: ord = $urandom_range(0, 15);
			endcase
			if (p == 1) begin
				bx = tmk_pkg::Q_MIN;
				by = tmk_pkg::Q_MAX;
			end else begin
				bx = rand_q();
				by = rand_q();
			end
			apply_settings(ord, bx, by);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_item(rand_item());
			end
			drain_block();
		end

		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d coefficient loads and %0d particle results (%0d lost)",
			sb.loads_seen, sb.kicks_checked, sb.lost_checked);
		$display("under %0d register settings with random gaps on both sides.", settings_used);
		if (sb.errors + sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
